FILE: sv/base64_stream_encoder_macros.svh
// Assertion helpers shared by the encoder RTL.
// Each macro samples on the rising edge of clk and is idle while rst_n is low.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define B64SE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64se assertion failed");
`define B64SE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64se assertion failed");
`else
`define B64SE_ASSERT_SAME(label, ante, cons)
`define B64SE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/b64se_pkg.sv
package b64se_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [1:0] LAST_IDX   = 2'd3;

  // Number of bytes held by the front end.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       final_char;
  } out_word_t;

  // One group of four characters: sextet 0 is sent first.
  typedef struct packed {
    logic [3:0][5:0] sextets;
    logic [1:0]      pad_cnt;
    logic            fin;
  } grp_t;

  typedef struct packed {
    logic [1:0] held_cnt;
    logic       push;
  } front_status_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'h41;
    end else if (v < 6'd52) begin
      c = w + 8'h47;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

FILE: sv/base64_stream_encoder.sv
// A word that closes a group is written to the group queue, popped into the back end's
// group register, and its first character is then loaded into the output register.
// Throughput: the character stage sends one character a cycle while out_ready stays high,
// four per group. Reset: rst_n is synchronous and active low; it empties the held bytes,
// the group queue and the output register, and the block is ready as soon as reset is released.
`include "base64_stream_encoder_macros.svh"

module base64_stream_encoder
  import b64se_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // The front end holds up to two bytes and, once a group is complete or the message
  // ends, pushes the group's four sextets with its pad count into a short queue.
  // The back end drains the queue one character per cycle, as out_ready allows, via an output
  // register, so the input side takes words while characters wait and the queue has room.

  logic          push_valid;
  logic          push_ready;
  grp_t          push_data;
  logic          pop_valid;
  logic          pop_ready;
  grp_t          pop_data;
  front_status_t front_status;

  b64se_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .status     (front_status)
  );

  b64se_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The front end never holds three bytes: the third always closes a group.
  `B64SE_ASSERT_SAME(a_held_bound, 1'b1, front_status.held_cnt != 2'd3)
  // A group enters the queue only on an accepted input word.
  `B64SE_ASSERT_SAME(a_push_on_accept, front_status.push, in_valid && in_ready)
  // A final character that is taken is not directly followed by another final character.
  `B64SE_ASSERT_NEXT(a_final_spacing, out_valid && out_ready && out_data.final_char,
                     !(out_valid && out_data.final_char))

endmodule

FILE: sv/b64se_front.sv
module b64se_front
  import b64se_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_word_t      in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output grp_t          push_data,
  output front_status_t status
);

  logic [15:0] held_r;
  logic [15:0] held_nxt;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic [23:0] word;
  logic [1:0]  pad;
  logic        emit;
  logic        acc;

  assign in_ready = push_ready;
  assign acc      = in_valid && push_ready;

  // Assemble the 24-bit group, zero-filling any bytes that a short message lacks.
  always_comb begin
    case (cnt_r)
      HELD_TWO: begin
        word = {held_r, in_data.data_byte};
        pad  = 2'd0;
        emit = 1'b1;
      end
      HELD_ONE: begin
        word = {held_r[15:8], in_data.data_byte, 8'h00};
        pad  = 2'd1;
        emit = in_data.end_of_message;
      end
      default: begin
        word = {in_data.data_byte, 16'h0000};
        pad  = 2'd2;
        emit = in_data.end_of_message;
      end
    endcase
  end

  always_comb begin
    push_valid             = in_valid && emit;
    push_data.sextets[0]   = word[23:18];
    push_data.sextets[1]   = word[17:12];
    push_data.sextets[2]   = word[11:6];
    push_data.sextets[3]   = word[5:0];
    push_data.pad_cnt      = pad;
    push_data.fin          = in_data.end_of_message;
    status.held_cnt        = cnt_r;
    status.push            = push_valid && push_ready;
  end

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (acc) begin
      if (emit) begin
        cnt_nxt = HELD_NONE;
      end else if (cnt_r == HELD_ONE) begin
        held_nxt = {held_r[15:8], in_data.data_byte};
        cnt_nxt  = HELD_TWO;
      end else begin
        held_nxt = {in_data.data_byte, 8'h00};
        cnt_nxt  = HELD_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (!rst_n) begin
      cnt_r <= HELD_NONE;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/b64se_queue.sv
module b64se_queue
  import b64se_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  grp_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output grp_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] wptr_nxt;
  logic [PTR_W-1:0] rptr_r;
  logic [PTR_W-1:0] rptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: sv/b64se_back.sv
module b64se_back
  import b64se_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  grp_t      pop_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  grp_t      grp_r;
  grp_t      grp_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic      busy_r;
  logic      busy_nxt;
  logic      ovld_r;
  logic      ovld_nxt;
  out_word_t odata_r;
  out_word_t odata_nxt;
  logic      load;
  logic      is_pad;
  out_word_t cur;

  assign load      = busy_r && (!ovld_r || out_ready);
  assign pop_ready = !busy_r || (load && (idx_r == LAST_IDX));
  assign out_valid = ovld_r;
  assign out_data  = odata_r;

  // Pads fill the tail of the group: one for two data bytes, two for one.
  always_comb begin
    is_pad = ((idx_r == LAST_IDX) && (grp_r.pad_cnt != 2'd0)) ||
             ((idx_r == 2'd2) && (grp_r.pad_cnt == 2'd2));
    cur.out_char   = is_pad ? PAD_CHAR : sextet_char(grp_r.sextets[idx_r]);
    cur.final_char = grp_r.fin && (idx_r == LAST_IDX);
  end

  always_comb begin
    grp_nxt   = grp_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;
    ovld_nxt  = ovld_r;
    odata_nxt = odata_r;
    if (out_ready) begin
      ovld_nxt = 1'b0;
    end
    if (load) begin
      ovld_nxt  = 1'b1;
      odata_nxt = cur;
      idx_nxt   = idx_r + 1'b1;
      if (idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop_valid && pop_ready) begin
      grp_nxt  = pop_data;
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    grp_r   <= grp_nxt;
    odata_r <= odata_nxt;
    if (!rst_n) begin
      idx_r  <= 2'd0;
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
    end
  end

endmodule

FILE: tb/sv/tb.sv
module tb
  import b64se_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Longest run of cycles with no word accepted on either channel before the run is
  // abandoned. The deliberate receiver hold-off is the longest quiet stretch, so the
  // limit is several times that.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int HOLD_OFF_CYCLES = 300;
  // Cycles allowed after the last expected character for any stray output to show.
  localparam int TAIL_CYCLES = 10;

  // The standard alphabet, first symbol in the most significant byte.
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // Predictor state: the bytes held while a group of three is being collected.
  logic [15:0] held_bytes;
  logic [1:0]  held_count;

  // Characters still owed by the encoder, oldest first.
  out_word_t expected_chars[$];

  // Stimulus controls shared between the test tasks and the receiver.
  bit quiet;       // no idling on either side
  bit hold_req;    // ask the receiver for one long hold-off

  int error_count;
  int words_sent;
  int chars_checked;
  int messages_closed;
  int idle_cycles;

  base64_stream_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Maps a six-bit value onto its character in the standard alphabet.
  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    return B64_ALPHABET[(63 - v) * 8 +: 8];
  endfunction

  task automatic queue_char(input logic [7:0] c, input logic fin);
    out_word_t w;
    w.out_char   = c;
    w.final_char = fin;
    expected_chars.push_back(w);
  endtask

  // Works out the characters that one accepted word causes and updates the held bytes.
  // A group completes either on its third byte or on the byte marked as last; in the
  // second case the missing bits are zero and the group is padded with '='.
  task automatic encode_byte(input in_word_t w);
    logic [7:0] b;
    logic [7:0] b0;
    logic [7:0] b1;
    b  = w.data_byte;
    b0 = held_bytes[15:8];
    b1 = held_bytes[7:0];
    if (held_count == HELD_TWO) begin
      // Third byte of a group: four full characters, final mark only if it is the last.
      queue_char(b64_symbol(b0[7:2]), 1'b0);
      queue_char(b64_symbol({b0[1:0], b1[7:4]}), 1'b0);
      queue_char(b64_symbol({b1[3:0], b[7:6]}), 1'b0);
      queue_char(b64_symbol(b[5:0]), w.end_of_message);
      held_bytes = '0;
      held_count = HELD_NONE;
    end else if (!w.end_of_message) begin
      // The group is not complete yet, so the byte is only held.
      if (held_count == HELD_ONE) begin
        held_bytes[7:0] = b;
        held_count      = HELD_TWO;
      end else begin
        held_bytes = {b, 8'h00};
        held_count = HELD_ONE;
      end
    end else if (held_count == HELD_ONE) begin
      // Last byte closes a group of two: three characters and one pad.
      queue_char(b64_symbol(b0[7:2]), 1'b0);
      queue_char(b64_symbol({b0[1:0], b[7:4]}), 1'b0);
      queue_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
      queue_char(PAD_CHAR, 1'b1);
      held_bytes = '0;
      held_count = HELD_NONE;
    end else begin
      // Last byte closes a group of one: two characters and two pads.
      queue_char(b64_symbol(b[7:2]), 1'b0);
      queue_char(b64_symbol({b[1:0], 4'b0000}), 1'b0);
      queue_char(PAD_CHAR, 1'b0);
      queue_char(PAD_CHAR, 1'b1);
      held_bytes = '0;
      held_count = HELD_NONE;
    end
  endtask

  // Monitor and checker. Both channels are sampled at the rising edge; accepted input
  // words feed the predictor and accepted output words are compared with the oldest
  // expected character. The encoder's latency means an output word never depends on an
  // input word accepted at the same edge.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        encode_byte(in_data);
        words_sent++;
        if (in_data.end_of_message) begin
          messages_closed++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected word: out_char %h final_char %b",
                 out_data.out_char, out_data.final_char);
          error_count++;
        end else begin
          exp_w = expected_chars.pop_front();
          chars_checked++;
          if (out_data.out_char !== exp_w.out_char) begin
            $error("out_char: expected %h, actual %h", exp_w.out_char, out_data.out_char);
            error_count++;
          end
          if (out_data.final_char !== exp_w.final_char) begin
            $error("final_char: expected %b, actual %b",
                   exp_w.final_char, out_data.final_char);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel accepts a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired with %0d characters outstanding",
               expected_chars.size());
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver. Ready changes at the falling edge only. It stalls in random bursts, gives
  // one long hold-off on request, and stays ready throughout once the quiet phase starts.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offers one word and returns at the rising edge where it is accepted. Valid is only
  // lowered for a gap; otherwise it stays high and the next word follows straight on.
  task automatic send_word(input logic [7:0] b, input logic eom);
    in_word_t w;
    w.data_byte      = b;
    w.end_of_message = eom;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_word(b, i == len - 1);
    end
  endtask

  // Extreme bytes, every padding length, groups that give '+' and '/', and a message
  // that runs past one group, so the held bytes must be cleared for the next message.
  task automatic test_directed();
    send_word(8'h00, 1'b1);                            // one byte: two pads
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0); send_word(8'hFF, 1'b1);    // two bytes: one pad
    send_word(8'hFF, 1'b0); send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b0); send_word(8'h00, 1'b0); send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0); send_word(8'hFF, 1'b0); send_word(8'hFF, 1'b1);
    send_word(8'hFB, 1'b0); send_word(8'hFF, 1'b0); send_word(8'hBF, 1'b1); // "+/+/"
    send_word(8'h4D, 1'b0); send_word(8'h61, 1'b0); send_word(8'h6E, 1'b0); // "Man" ...
    send_word(8'h4D, 1'b1);                                                 // ... "TQ=="
    send_word(8'hF8, 1'b1);
    send_word(8'hA5, 1'b0); send_word(8'h5A, 1'b0); send_word(8'hC3, 1'b0);
    send_word(8'h3C, 1'b0); send_word(8'h81, 1'b1);
  endtask

  // Mostly whole messages of random length with random content; now and then a run of
  // words whose last-of-message marks are random, so messages end at any point.
  task automatic test_random_messages();
    int target;
    target = words_sent + 270;
    while (words_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat (5) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 9) == 0) begin
        send_message($urandom_range(10, 24));
      end else begin
        send_message($urandom_range(1, 9));
      end
    end
  endtask

  // The receiver holds off for a long stretch while a long message keeps arriving, so
  // the group queue fills and the encoder has to stall its input.
  task automatic test_output_hold_off();
    @(negedge clk);
    hold_req = 1'b1;
    send_message(30);
  endtask

  // Final part with no idling on either side, so the encoder runs at its full rate.
  task automatic test_back_to_back();
    int target;
    quiet  = 1'b1;
    target = words_sent + 36;
    while (words_sent < target) begin
      send_message($urandom_range(1, 7));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    held_bytes      = '0;
    held_count      = HELD_NONE;
    error_count     = 0;
    words_sent      = 0;
    chars_checked   = 0;
    messages_closed = 0;
    idle_cycles     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_messages();
    test_output_hold_off();
    test_back_to_back();

    @(negedge clk);
    in_valid = 1'b0;

    // Drain: the watchdog ends the run if characters go missing.
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d bytes in %0d messages encoded, %0d characters checked,",
             words_sent, messages_closed, chars_checked);
    $display("tb: with random stalls, one long output hold-off and a back-to-back tail");
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
